// File: sv/assert_macros.svh
// Assertion helpers; the user must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: sv/qusq_pkg.sv
package qusq_pkg;

    localparam int NCORNER     = 4;
    localparam int COORD_W     = 24;   // input coordinate
    localparam int DIFF_W      = 25;   // edge axis component
    localparam int SUM_W       = 26;   // axis component sum, also holds 1.0
    localparam int PROD_W      = 49;   // coordinate x axis component
    localparam int SQ_W        = 50;   // axis component squared
    localparam int ARITH_W     = 52;   // projections and scaled view bounds
    localparam int IN_TDATA_W  = 2 * NCORNER * COORD_W;
    localparam int OUT_TDATA_W = 8;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SQ_W-1:0]    sq_t;
    typedef logic signed [ARITH_W-1:0] arith_t;

endpackage

// File: sv/qusq_range4.sv
// Minimum and maximum of four signed values, two compare levels.
module qusq_range4
    import qusq_pkg::*;
#(
    parameter int W = 24
)
(
    input  logic signed [W-1:0] v [NCORNER],
    output logic signed [W-1:0] lo,
    output logic signed [W-1:0] hi
);

    logic signed [W-1:0] lo01;
    logic signed [W-1:0] lo23;
    logic signed [W-1:0] hi01;
    logic signed [W-1:0] hi23;

    always_comb
    begin
        lo01 = (v[1] < v[0]) ? v[1] : v[0];
        hi01 = (v[1] > v[0]) ? v[1] : v[0];
        lo23 = (v[3] < v[2]) ? v[3] : v[2];
        hi23 = (v[3] > v[2]) ? v[3] : v[2];
        lo   = (lo23 < lo01) ? lo23 : lo01;
        hi   = (hi23 > hi01) ? hi23 : hi01;
    end

endmodule

// File: sv/quad_unit_square_overlap.sv
// Quad versus unit view square overlap test.
//
// Slave stream: one transaction carries the four corners of a quad, each
// row and column a signed fixed-point value with COORD_FRAC_BITS fraction
// bits. Master stream: one transaction per input carries the 1-bit verdict
// (1 = quad touches or overlaps [0,1] x [0,1]).
//
// Five register stages: corner checks and edge axes, multipliers, adders,
// min/max trees, final interval compares into the output register.
// One transaction per cycle is sustained while m_axis_tready stays high;
// there is a single multiplier stage, and every unit is fully pipelined.
//
// Reset clears every stage valid bit; data registers are not reset.
// When the receiver stalls, each stage holds only while the stage after it
// is full, so bubbles are squeezed out and the input keeps being taken
// until the whole pipe is full; nothing is dropped or repeated.
`include "assert_macros.svh"

module quad_unit_square_overlap
    import qusq_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // top_left_row, top_left_col, top_right_row, top_right_col,
    // bottom_right_row, bottom_right_col, bottom_left_row, bottom_left_col
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // overlaps, then zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // 1.0 in coordinate units
    localparam sum_t ONE = sum_t'(64'sd1 <<< COORD_FRAC_BITS);

    // ---------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its successor loads
    // ---------------------------------------------------------------
    logic s1_en, s2_en, s3_en, s4_en, out_en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic v1_next, v2_next, v3_next, v4_next, out_valid_next;

    assign out_en = !out_valid_reg || m_axis_tready;
    assign s4_en  = !v4_reg || out_en;
    assign s3_en  = !v3_reg || s4_en;
    assign s2_en  = !v2_reg || s3_en;
    assign s1_en  = !v1_reg || s2_en;

    assign s_axis_tready = s1_en;

    always_comb
    begin
        v1_next        = s1_en  ? s_axis_tvalid : v1_reg;
        v2_next        = s2_en  ? v1_reg        : v2_reg;
        v3_next        = s3_en  ? v2_reg        : v3_reg;
        v4_next        = s4_en  ? v3_reg        : v4_reg;
        out_valid_next = out_en ? v4_reg        : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            v4_reg        <= v4_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: unpack, edge axes, corner-in-square, bounding reject
    // ---------------------------------------------------------------
    coord_t in_row [NCORNER];
    coord_t in_col [NCORNER];
    coord_t row_lo, row_hi, col_lo, col_hi;

    always_comb
    begin
        for (int i = 0; i < NCORNER; i++)
        begin
            in_row[i] = s_axis_tdata[(2*i)*COORD_W +: COORD_W];
            in_col[i] = s_axis_tdata[(2*i+1)*COORD_W +: COORD_W];
        end
    end

    qusq_range4 #(.W(COORD_W)) u_row_range
    (
        .v  (in_row),
        .lo (row_lo),
        .hi (row_hi)
    );

    qusq_range4 #(.W(COORD_W)) u_col_range
    (
        .v  (in_col),
        .lo (col_lo),
        .hi (col_hi)
    );

    coord_t s1_row_reg [NCORNER];
    coord_t s1_col_reg [NCORNER];
    diff_t  s1_ar_reg, s1_ac_reg, s1_br_reg, s1_bc_reg;
    logic   s1_t1_reg, s1_rej_reg;
    diff_t  s1_ar_next, s1_ac_next, s1_br_next, s1_bc_next;
    logic   s1_t1_next, s1_rej_next;

    always_comb
    begin
        // axis A = top-left - top-right, axis B = bottom-right - top-right
        s1_ar_next = DIFF_W'(in_row[0]) - DIFF_W'(in_row[1]);
        s1_ac_next = DIFF_W'(in_col[0]) - DIFF_W'(in_col[1]);
        s1_br_next = DIFF_W'(in_row[2]) - DIFF_W'(in_row[1]);
        s1_bc_next = DIFF_W'(in_col[2]) - DIFF_W'(in_col[1]);
        s1_t1_next = (in_col[0] >= 0) && (in_col[0] <= ONE) &&
                     (in_row[0] >= 0) && (in_row[0] <= ONE);
        s1_rej_next = (col_hi < 0) || (col_lo > ONE) ||
                      (row_hi < 0) || (row_lo > ONE);
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_row_reg <= in_row;
            s1_col_reg <= in_col;
            s1_ar_reg  <= s1_ar_next;
            s1_ac_reg  <= s1_ac_next;
            s1_br_reg  <= s1_br_next;
            s1_bc_reg  <= s1_bc_next;
            s1_t1_reg  <= s1_t1_next;
            s1_rej_reg <= s1_rej_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: corner projections, squared axis lengths, view bounds
    // (view corners scale by 1.0 > 0, so their range is taken unscaled)
    // ---------------------------------------------------------------
    sum_t vw_a [NCORNER];
    sum_t vw_b [NCORNER];
    sum_t vlo_a, vhi_a, vlo_b, vhi_b;

    always_comb
    begin
        vw_a[0] = '0;
        vw_a[1] = SUM_W'(s1_ac_reg);
        vw_a[2] = SUM_W'(s1_ar_reg);
        vw_a[3] = SUM_W'(s1_ar_reg) + SUM_W'(s1_ac_reg);
        vw_b[0] = '0;
        vw_b[1] = SUM_W'(s1_bc_reg);
        vw_b[2] = SUM_W'(s1_br_reg);
        vw_b[3] = SUM_W'(s1_br_reg) + SUM_W'(s1_bc_reg);
    end

    qusq_range4 #(.W(SUM_W)) u_view_a_range
    (
        .v  (vw_a),
        .lo (vlo_a),
        .hi (vhi_a)
    );

    qusq_range4 #(.W(SUM_W)) u_view_b_range
    (
        .v  (vw_b),
        .lo (vlo_b),
        .hi (vhi_b)
    );

    prod_t s2_pa_r_reg [NCORNER];
    prod_t s2_pa_c_reg [NCORNER];
    prod_t s2_pb_r_reg [NCORNER];
    prod_t s2_pb_c_reg [NCORNER];
    prod_t s2_pa_r_next [NCORNER];
    prod_t s2_pa_c_next [NCORNER];
    prod_t s2_pb_r_next [NCORNER];
    prod_t s2_pb_c_next [NCORNER];
    sq_t   s2_sq_ar_reg, s2_sq_ac_reg, s2_sq_br_reg, s2_sq_bc_reg;
    sq_t   s2_sq_ar_next, s2_sq_ac_next, s2_sq_br_next, s2_sq_bc_next;
    sum_t  s2_vlo_a_reg, s2_vhi_a_reg, s2_vlo_b_reg, s2_vhi_b_reg;
    logic  s2_t1_reg, s2_rej_reg;

    always_comb
    begin
        for (int i = 0; i < NCORNER; i++)
        begin
            s2_pa_r_next[i] = s1_row_reg[i] * s1_ar_reg;
            s2_pa_c_next[i] = s1_col_reg[i] * s1_ac_reg;
            s2_pb_r_next[i] = s1_row_reg[i] * s1_br_reg;
            s2_pb_c_next[i] = s1_col_reg[i] * s1_bc_reg;
        end
        s2_sq_ar_next = s1_ar_reg * s1_ar_reg;
        s2_sq_ac_next = s1_ac_reg * s1_ac_reg;
        s2_sq_br_next = s1_br_reg * s1_br_reg;
        s2_sq_bc_next = s1_bc_reg * s1_bc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            s2_pa_r_reg  <= s2_pa_r_next;
            s2_pa_c_reg  <= s2_pa_c_next;
            s2_pb_r_reg  <= s2_pb_r_next;
            s2_pb_c_reg  <= s2_pb_c_next;
            s2_sq_ar_reg <= s2_sq_ar_next;
            s2_sq_ac_reg <= s2_sq_ac_next;
            s2_sq_br_reg <= s2_sq_br_next;
            s2_sq_bc_reg <= s2_sq_bc_next;
            s2_vlo_a_reg <= vlo_a;
            s2_vhi_a_reg <= vhi_a;
            s2_vlo_b_reg <= vlo_b;
            s2_vhi_b_reg <= vhi_b;
            s2_t1_reg    <= s1_t1_reg;
            s2_rej_reg   <= s1_rej_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: projection sums and squared lengths
    // ---------------------------------------------------------------
    arith_t s3_poly_a_reg [NCORNER];
    arith_t s3_poly_b_reg [NCORNER];
    arith_t s3_poly_a_next [NCORNER];
    arith_t s3_poly_b_next [NCORNER];
    arith_t s3_aa_reg, s3_bb_reg, s3_aa_next, s3_bb_next;
    sum_t   s3_vlo_a_reg, s3_vhi_a_reg, s3_vlo_b_reg, s3_vhi_b_reg;
    logic   s3_t1_reg, s3_rej_reg;

    always_comb
    begin
        for (int i = 0; i < NCORNER; i++)
        begin
            s3_poly_a_next[i] = ARITH_W'(s2_pa_r_reg[i]) + ARITH_W'(s2_pa_c_reg[i]);
            s3_poly_b_next[i] = ARITH_W'(s2_pb_r_reg[i]) + ARITH_W'(s2_pb_c_reg[i]);
        end
        s3_aa_next = ARITH_W'(s2_sq_ar_reg) + ARITH_W'(s2_sq_ac_reg);
        s3_bb_next = ARITH_W'(s2_sq_br_reg) + ARITH_W'(s2_sq_bc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s3_en)
        begin
            s3_poly_a_reg <= s3_poly_a_next;
            s3_poly_b_reg <= s3_poly_b_next;
            s3_aa_reg     <= s3_aa_next;
            s3_bb_reg     <= s3_bb_next;
            s3_vlo_a_reg  <= s2_vlo_a_reg;
            s3_vhi_a_reg  <= s2_vhi_a_reg;
            s3_vlo_b_reg  <= s2_vlo_b_reg;
            s3_vhi_b_reg  <= s2_vhi_b_reg;
            s3_t1_reg     <= s2_t1_reg;
            s3_rej_reg    <= s2_rej_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: origin-in-quad test and projection ranges
    // The origin's projection on an axis is minus the top-right corner's.
    // ---------------------------------------------------------------
    arith_t pmin_a, pmax_a, pmin_b, pmax_b;
    arith_t am_a, am_b;
    logic   s4_t2_next;

    qusq_range4 #(.W(ARITH_W)) u_poly_a_range
    (
        .v  (s3_poly_a_reg),
        .lo (pmin_a),
        .hi (pmax_a)
    );

    qusq_range4 #(.W(ARITH_W)) u_poly_b_range
    (
        .v  (s3_poly_b_reg),
        .lo (pmin_b),
        .hi (pmax_b)
    );

    always_comb
    begin
        am_a       = -s3_poly_a_reg[1];
        am_b       = -s3_poly_b_reg[1];
        s4_t2_next = (am_b >= 0) && (am_b <= s3_bb_reg) &&
                     (am_a >= 0) && (am_a <= s3_aa_reg);
    end

    arith_t s4_pmin_a_reg, s4_pmax_a_reg, s4_pmin_b_reg, s4_pmax_b_reg;
    sum_t   s4_vlo_a_reg, s4_vhi_a_reg, s4_vlo_b_reg, s4_vhi_b_reg;
    logic   s4_t1_reg, s4_t2_reg, s4_rej_reg;

    always_ff @(posedge clk)
    begin
        if (s4_en)
        begin
            s4_pmin_a_reg <= pmin_a;
            s4_pmax_a_reg <= pmax_a;
            s4_pmin_b_reg <= pmin_b;
            s4_pmax_b_reg <= pmax_b;
            s4_vlo_a_reg  <= s3_vlo_a_reg;
            s4_vhi_a_reg  <= s3_vhi_a_reg;
            s4_vlo_b_reg  <= s3_vlo_b_reg;
            s4_vhi_b_reg  <= s3_vhi_b_reg;
            s4_t1_reg     <= s3_t1_reg;
            s4_t2_reg     <= s4_t2_next;
            s4_rej_reg    <= s3_rej_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: interval separation on both axes, verdict
    // ---------------------------------------------------------------
    arith_t vmin_a, vmax_a, vmin_b, vmax_b;
    logic   sep_a, sep_b;
    logic   result_reg, result_next;

    always_comb
    begin
        vmin_a = ARITH_W'(s4_vlo_a_reg) <<< COORD_FRAC_BITS;
        vmax_a = ARITH_W'(s4_vhi_a_reg) <<< COORD_FRAC_BITS;
        vmin_b = ARITH_W'(s4_vlo_b_reg) <<< COORD_FRAC_BITS;
        vmax_b = ARITH_W'(s4_vhi_b_reg) <<< COORD_FRAC_BITS;
        sep_a  = (vmin_a > s4_pmax_a_reg) || (s4_pmin_a_reg > vmax_a);
        sep_b  = (vmin_b > s4_pmax_b_reg) || (s4_pmin_b_reg > vmax_b);
        // corner inside or origin inside win; then reject; then separation
        result_next = s4_t1_reg || s4_t2_reg || (!s4_rej_reg && !sep_a && !sep_b);
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, result_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_IMPLIES(a_ready_when_out_empty, !m_axis_tvalid, s_axis_tready,
        "input not ready although the output register is empty")
    `ASSERT_NEXT(a_early_accept, out_en && v4_reg && (s4_t1_reg || s4_t2_reg),
        m_axis_tvalid && m_axis_tdata[0], "corner or origin hit did not give overlap")
    `ASSERT_NEXT(a_bound_reject, out_en && v4_reg && !s4_t1_reg && !s4_t2_reg && s4_rej_reg,
        m_axis_tvalid && !m_axis_tdata[0], "bounding reject did not give miss")
    `ASSERT_IMPLIES(a_sq_len_pos, v3_reg, !s3_aa_reg[ARITH_W-1] && !s3_bb_reg[ARITH_W-1],
        "squared axis length negative")

endmodule
